FILE: rtl/dpld_pkg.sv
// Shared types, codes and constant arithmetic for the date period length block.
// No dependencies; compile first.
`default_nettype none

package dpld_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 16;
  localparam int unsigned StatW  = 2;

  // Ordinal day numbers of every reachable date fit in 23 bits.
  localparam int unsigned OrdW = 23;
  localparam int unsigned AccW = OrdW + 1;

  // floor(x / 100) for x below 2**15 as (x * 5243) >> 19.
  localparam int unsigned DivInW   = 15;
  localparam int unsigned DivQW    = 8;
  localparam int unsigned RecipW   = 13;
  localparam int unsigned RecipSh  = 19;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BEFORE = 2'd1,
    STAT_SAT    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CALC,
    FS_FINISH,
    FS_DONE
  } fsm_t;

  // One term of an ordinal, fed through the shared add/subtract unit.
  typedef enum logic [2:0] {
    TM_YEAR,
    TM_Q4,
    TM_Q100,
    TM_Q400,
    TM_MON,
    TM_DAY
  } term_t;

  function automatic logic [DivQW-1:0] div100(input logic [DivInW-1:0] x);
    logic [DivInW+RecipW-1:0] prod;
    prod = (DivInW+RecipW)'(x) * (DivInW+RecipW)'(Recip100);
    return prod[RecipSh+DivQW-1:RecipSh];
  endfunction

  // Days in the months before month m of a common year; months past 12 stop at 365.
  function automatic logic [8:0] month_cum(input logic [MonthW-1:0] m);
    logic [8:0] r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      4'd12:      r = 9'd334;
      default:    r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dpld_if.sv
// Valid/ready channel interfaces for the date period length block.
// Depends on dpld_pkg for field widths.
`default_nettype none

interface dpld_in_if;
  import dpld_pkg::*;

  logic              valid;
  logic              ready;
  logic [DayW-1:0]   start_day;
  logic [MonthW-1:0] start_month;
  logic [YearW-1:0]  start_year;
  logic [DayW-1:0]   end_day;
  logic [MonthW-1:0] end_month;
  logic [YearW-1:0]  end_year;
  logic              include_end;

  modport source (
    output valid, start_day, start_month, start_year,
    output end_day, end_month, end_year, include_end,
    input  ready
  );
  modport sink (
    input  valid, start_day, start_month, start_year,
    input  end_day, end_month, end_year, include_end,
    output ready
  );
endinterface

interface dpld_out_if;
  import dpld_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] day_count;
  logic [StatW-1:0]  status;

  modport source (output valid, day_count, status, input ready);
  modport sink (input valid, day_count, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/date_period_length_days_unit.sv
// Date period length: days from a Gregorian start date to an end date.
// Depends on dpld_pkg and the channel interfaces in dpld_if.sv.
//
// The block takes one request at a time on the request channel and returns one
// result on the result channel. Each date is turned into an ordinal day number
// (days before its year counted from year 0, plus the days of the months before
// its month with the leap day, plus the day), and the result is end minus start,
// plus one when include_end is set. One shared 24-bit add/subtract unit builds
// both ordinals term by term into a single accumulator under a small sequencer;
// a shared reciprocal multiplier supplies the divisions by 100 and 400. The result
// turns valid after twelve accumulator steps, six for each date, and one step that
// compares against the limit and registers the result.
// The request channel is ready again the cycle after the result has been taken,
// so no new request is taken until the last result has been taken. When the
// end lies before the start the result is a count of 0 with status 1. When the
// count exceeds the limit (MAX_DAYS, capped at 65535) it saturates with status 2.
// Fields are used at face value: day 0 is the last day of the month before, a
// day past the month's end runs into the next month, months above 12 count the
// whole year, and year 0 is a leap year.
`default_nettype none

module date_period_length_days_unit #(
  parameter int unsigned MAX_DAYS = 65535
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dpld_in_if.sink     request,
  dpld_out_if.source  result
);
  import dpld_pkg::*;

  localparam logic [CountW-1:0] Limit =
    (MAX_DAYS > 65535) ? {CountW{1'b1}} : CountW'(MAX_DAYS);

  fsm_t state, state_next;
  term_t term, term_next;
  logic side, side_next;            // 0: start date, subtracted; 1: end date, added

  logic [DayW-1:0]   s_day, e_day;
  logic [MonthW-1:0] s_mon, e_mon;
  logic [YearW-1:0]  s_year, e_year;
  logic              inc;

  logic [AccW-1:0]   acc, acc_next;
  logic [CountW-1:0] count_q;
  status_t           status_q;
  logic [CountW-1:0] count_next;
  status_t           status_next;

  // Shared unit operands
  logic [YearW-1:0]  y;
  logic [MonthW-1:0] m;
  logic [DayW-1:0]   d;
  logic [DivInW-1:0] y99, y399;
  logic [DivInW-1:0] div_op;
  logic [DivQW-1:0]  q;
  logic              leap;
  logic [OrdW-1:0]   term_val;
  logic              term_sub;
  logic [AccW-1:0]   sum;

  assign request.ready    = (state == FS_IDLE);
  assign result.valid     = (state == FS_DONE);
  assign result.day_count = count_q;
  assign result.status    = status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
      term  <= TM_YEAR;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      term  <= term_next;
      side  <= side_next;
    end
  end

  // Payload: capture the request, hold the accumulator and the result.
  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      s_day  <= request.start_day;
      s_mon  <= request.start_month;
      s_year <= request.start_year;
      e_day  <= request.end_day;
      e_mon  <= request.end_month;
      e_year <= request.end_year;
      inc    <= request.include_end;
    end
    acc <= acc_next;
    if (state == FS_FINISH) begin
      count_q  <= count_next;
      status_q <= status_next;
    end
  end

  // Term selection for the shared unit
  always_comb begin
    y    = side ? e_year : s_year;
    m    = side ? e_mon  : s_mon;
    d    = side ? e_day  : s_day;
    y99  = DivInW'(y) + DivInW'(99);
    y399 = DivInW'(y) + DivInW'(399);
    case (term)
      TM_Q100: div_op = y99;
      TM_Q400: div_op = y399 >> 2;
      default: div_op = DivInW'(y);
    endcase
    q = div100(div_op);
    // Leap when divisible by 4 and not by 100, or by 400 (q is floor(y/100) here).
    leap = (y[1:0] == 2'b00) &&
           ((DivInW'(y) != DivInW'(q) * DivInW'(100)) || (q[1:0] == 2'b00));
    case (term)
      TM_YEAR: term_val = OrdW'(y) * OrdW'(365);
      TM_Q4:   term_val = OrdW'((DivInW'(y) + DivInW'(3)) >> 2);
      TM_Q100: term_val = OrdW'(q);
      TM_Q400: term_val = OrdW'(q);
      TM_MON:  term_val = OrdW'(month_cum(m)) + OrdW'((m > 4'd2) && leap);
      TM_DAY:  term_val = OrdW'(d);
      default: term_val = '0;
    endcase
    term_sub = (term == TM_Q100) ^ !side;
    sum = term_sub ? acc - AccW'(term_val) : acc + AccW'(term_val);
  end

  // Sequencer: next state, accumulator and result
  always_comb begin
    state_next  = state;
    term_next   = term;
    side_next   = side;
    acc_next    = acc;
    count_next  = '0;
    status_next = STAT_OK;

    // Limit check on the finished difference
    if (acc[AccW-1]) begin
      count_next  = '0;
      status_next = STAT_BEFORE;
    end else if ((acc + AccW'(inc)) > AccW'(Limit)) begin
      count_next  = Limit;
      status_next = STAT_SAT;
    end else begin
      count_next  = CountW'(acc + AccW'(inc));
      status_next = STAT_OK;
    end

    case (state)
      FS_IDLE: begin
        if (request.valid) begin
          state_next = FS_CALC;
          term_next  = TM_YEAR;
          side_next  = 1'b0;
          acc_next   = '0;
        end
      end
      FS_CALC: begin
        acc_next = sum;
        case (term)
          TM_YEAR: term_next = TM_Q4;
          TM_Q4:   term_next = TM_Q100;
          TM_Q100: term_next = TM_Q400;
          TM_Q400: term_next = TM_MON;
          TM_MON:  term_next = TM_DAY;
          default: begin
            term_next = TM_YEAR;
            if (side) begin
              state_next = FS_FINISH;
            end else begin
              side_next = 1'b1;
            end
          end
        endcase
      end
      FS_FINISH: begin
        state_next = FS_DONE;
      end
      FS_DONE: begin
        if (result.ready) begin
          state_next = FS_IDLE;
        end
      end
      default: begin
        state_next = FS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: bench/date_period_length_days_unit_tb.sv
// Testbench for date_period_length_days_unit: a directed table of date pairs, then random pairs,
// every result checked against its typed table value or an in-bench day-number predictor.
// Depends on dpld_pkg, the channel interfaces in dpld_if.sv and the RTL of the block.
`default_nettype none

module date_period_length_days_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dpld_pkg::*;

  // The block runs with its default limit of 65535.
  localparam int unsigned SpanLimit   = 65535;
  localparam int unsigned RandCount   = 78;
  // The last requests run with no idling on either side.
  localparam int unsigned QuietTail   = 20;
  // Long receiver hold-off, long enough to back the block up into its request channel.
  localparam int unsigned StallCycles = 300;
  // About 100 requests plus idling and the hold-off stay far below this.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned DirRows     = 22;

  typedef struct packed {
    logic [DayW-1:0]   sd;
    logic [MonthW-1:0] sm;
    logic [YearW-1:0]  sy;
    logic [DayW-1:0]   ed;
    logic [MonthW-1:0] em;
    logic [YearW-1:0]  ey;
    logic              inc;
  } date_pair_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    status_t           status;
  } span_t;

  // One row of the directed table; typed rows carry the result read straight off the rules.
  typedef struct {
    int unsigned sd, sm, sy, ed, em, ey, inc;
    int unsigned typed;
    int unsigned cnt;
    status_t     st;
  } dir_row_t;

  logic clk;
  logic rst;

  dpld_in_if  req_ch ();
  dpld_out_if res_ch ();

  date_period_length_days_unit dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch)
  );

  // Expected spans, oldest first, one per accepted request.
  span_t       span_q [$];
  int unsigned fails;
  // Typed expectation of the request now on the channel, held stable with valid.
  logic        row_typed;
  span_t       row_want;
  // Receiver controls: start the long hold-off once, and drop all idling at the end.
  logic        stress_go;
  logic        quiet;

  dir_row_t dir_tab [DirRows] = '{
    // equal dates, with and without the end day
    '{1, 1, 1, 1, 1, 1, 0, 1, 0, STAT_OK},
    '{1, 1, 1, 1, 1, 1, 1, 1, 1, STAT_OK},
    // end one day before start: zero whatever include_end says
    '{2, 1, 1, 1, 1, 1, 1, 1, 0, STAT_BEFORE},
    // widest legal span saturates
    '{1, 1, 1, 31, 12, 9999, 0, 1, SpanLimit, STAT_SAT},
    // all field bits high on both sides, equal
    '{31, 15, 16383, 31, 15, 16383, 1, 1, 1, STAT_OK},
    // all ones down to all zeros
    '{31, 15, 16383, 0, 0, 0, 1, 1, 0, STAT_BEFORE},
    '{0, 0, 0, 0, 0, 0, 0, 1, 0, STAT_OK},
    // right on the limit, one past it by include_end, and reaching it through include_end
    '{1, 1, 0, 6, 6, 179, 0, 0, 0, STAT_OK},
    '{1, 1, 0, 6, 6, 179, 1, 0, 0, STAT_OK},
    '{1, 1, 0, 5, 6, 179, 1, 0, 0, STAT_OK},
    // February across plain leap, century and 400-year rules
    '{28, 2, 2024, 1, 3, 2024, 0, 0, 0, STAT_OK},
    '{28, 2, 1900, 1, 3, 1900, 0, 0, 0, STAT_OK},
    '{28, 2, 2000, 1, 3, 2000, 0, 0, 0, STAT_OK},
    // day past the month end runs over, day zero runs back
    '{29, 2, 2023, 1, 3, 2023, 1, 0, 0, STAT_OK},
    '{0, 3, 2024, 29, 2, 2024, 1, 0, 0, STAT_OK},
    // months above 12 count the whole year
    '{1, 13, 2020, 1, 12, 2020, 0, 0, 0, STAT_OK},
    '{1, 15, 2020, 1, 13, 2020, 0, 0, 0, STAT_OK},
    '{31, 12, 1999, 1, 1, 2000, 1, 0, 0, STAT_OK},
    // year zero is leap
    '{1, 1, 0, 1, 1, 1, 0, 0, 0, STAT_OK},
    '{1, 1, 8191, 1, 1, 8192, 1, 0, 0, STAT_OK},
    '{15, 6, 2024, 14, 6, 2024, 0, 0, 0, STAT_OK},
    '{1, 1, 1, 1, 1, 180, 0, 0, 0, STAT_OK}
  };

  // ---------------------------------------------------------------------------------------------
  // Predictor: map each date to a day number counted from year 0, then take the difference.
  // ---------------------------------------------------------------------------------------------
  function automatic bit is_leap(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned common_month_len(input int unsigned m);
    case (m)
      2:            return 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic int unsigned day_number(input logic [DayW-1:0] d,
                                             input logic [MonthW-1:0] m,
                                             input logic [YearW-1:0] y);
    int unsigned yr;
    int unsigned total;
    yr    = y;
    total = yr * 365 + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400 + d;
    // Add the months before m; anything past December adds just the twelve real ones.
    for (int unsigned i = 1; i < m && i <= 12; i++) begin
      total += common_month_len(i);
      if (i == 2 && is_leap(yr)) total += 1;
    end
    return total;
  endfunction

  function automatic span_t predict_span(input date_pair_t p);
    span_t       r;
    int unsigned s_num;
    int unsigned e_num;
    int unsigned cnt;
    s_num = day_number(p.sd, p.sm, p.sy);
    e_num = day_number(p.ed, p.em, p.ey);
    if (e_num < s_num) begin
      r.count  = '0;
      r.status = STAT_BEFORE;
    end else begin
      cnt = e_num - s_num + p.inc;
      if (cnt > SpanLimit) begin
        r.count  = CountW'(SpanLimit);
        r.status = STAT_SAT;
      end else begin
        r.count  = CountW'(cnt);
        r.status = STAT_OK;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Random date pairs, weighted toward spans that land in every result class.
  // ---------------------------------------------------------------------------------------------
  function automatic date_pair_t make_random_pair();
    date_pair_t  p;
    int unsigned pick;
    int unsigned y;
    int unsigned off;
    logic [DayW-1:0]   td;
    logic [MonthW-1:0] tm;
    logic [YearW-1:0]  ty;
    pick  = $urandom_range(0, 99);
    y     = $urandom_range(1, 9999);
    p.sd  = DayW'($urandom_range(1, 31));
    p.sm  = MonthW'($urandom_range(1, 12));
    p.sy  = YearW'(y);
    p.ed  = DayW'($urandom_range(1, 31));
    p.em  = MonthW'($urandom_range(1, 12));
    p.ey  = YearW'(y + $urandom_range(0, 2));
    p.inc = 1'($urandom_range(0, 1));
    if (pick < 30) begin
      // short span: keep the defaults
    end else if (pick < 45) begin
      // about 180 years: straddle the saturation point
      p.ey = YearW'(y + $urandom_range(170, 190));
    end else if (pick < 55) begin
      // pinned just around the limit
      p.sd = DayW'(1);
      p.sm = MonthW'(1);
      p.sy = YearW'(0);
      p.ed = DayW'($urandom_range(1, 12));
      p.em = MonthW'(6);
      p.ey = YearW'(179);
    end else if (pick < 70) begin
      // swap the short span around so the end comes first
      td = p.sd; tm = p.sm; ty = p.sy;
      p.sd = p.ed; p.sm = p.em; p.sy = p.ey;
      p.ed = td; p.em = tm; p.ey = ty;
    end else if (pick < 80) begin
      p.ed = p.sd;
      p.em = p.sm;
      p.ey = p.sy;
    end else if (pick < 90) begin
      // raw field noise over the full widths
      p = date_pair_t'($bits(date_pair_t)'({$urandom, $urandom}));
    end else begin
      // end of February in years that test each leap rule
      case ($urandom_range(0, 4))
        0:       off = 0;
        1:       off = 100;
        2:       off = 200;
        3:       off = 4;
        default: off = 3;
      endcase
      y    = $urandom_range(0, 40) * 400 + off;
      p.sd = DayW'($urandom_range(28, 29));
      p.sm = MonthW'(2);
      p.sy = YearW'(y);
      p.ed = $urandom_range(0, 1) ? DayW'(1) : DayW'(29);
      p.em = (p.ed == 1) ? MonthW'(3) : MonthW'(2);
      p.ey = YearW'(y);
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
    fails++;
  endtask

  // Offer one request at the falling edge and hold it until the block takes it.
  task automatic offer(input date_pair_t p, input bit typed, input span_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    req_ch.start_day   <= p.sd;
    req_ch.start_month <= p.sm;
    req_ch.start_year  <= p.sy;
    req_ch.end_day     <= p.ed;
    req_ch.end_month   <= p.em;
    req_ch.end_year    <= p.ey;
    req_ch.include_end <= p.inc;
    row_typed          <= typed;
    row_want           <= want;
    req_ch.valid       <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Clock and watchdog.
  // ---------------------------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("timeout after %0d cycles, %0d spans still expected", CycleLimit, span_q.size());
    $display("** date_period_length_days_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------------------------
  // Monitor: record the expectation of each accepted request, check each accepted result.
  // Both channels are sampled at the rising edge; the bench drives only at the falling edge.
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk) begin
    span_t      want;
    date_pair_t seen;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        seen.sd  = req_ch.start_day;
        seen.sm  = req_ch.start_month;
        seen.sy  = req_ch.start_year;
        seen.ed  = req_ch.end_day;
        seen.em  = req_ch.end_month;
        seen.ey  = req_ch.end_year;
        seen.inc = req_ch.include_end;
        span_q = {span_q, (row_typed ? row_want : predict_span(seen))};
      end
      if (res_ch.valid && res_ch.ready) begin
        if (span_q.size() == 0) begin
          report_mismatch("result with no request pending, day_count", res_ch.day_count, 0);
        end else begin
          want = span_q.pop_front();
          if (res_ch.day_count !== want.count)
            report_mismatch("day_count", res_ch.day_count, want.count);
          if (res_ch.status !== want.status)
            report_mismatch("status", res_ch.status, want.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Receiver: random bursts of back-pressure, one long hold-off, and none in the tail.
  // ---------------------------------------------------------------------------------------------
  initial begin
    int unsigned idle_left;
    int unsigned held_for;
    bit          held;
    idle_left    = 0;
    held         = 1'b0;
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (stress_go && !held) begin
        // Hold off long enough that the block fills and stalls its request channel.
        held         = 1'b1;
        res_ch.ready <= 1'b0;
        held_for     = 0;
        while (held_for < StallCycles) begin
          @(negedge clk);
          held_for++;
        end
      end else begin
        if (idle_left > 0 && !quiet) begin
          res_ch.ready <= 1'b0;
          idle_left--;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          res_ch.ready <= 1'b0;
          idle_left = $urandom_range(1, 12) - 1;
        end else begin
          res_ch.ready <= 1'b1;
          idle_left = 0;
        end
        @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Sender and end of run.
  // ---------------------------------------------------------------------------------------------
  initial begin
    date_pair_t p;
    span_t      want;
    fails              = 0;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.start_day   = '0;
    req_ch.start_month = '0;
    req_ch.start_year  = '0;
    req_ch.end_day     = '0;
    req_ch.end_month   = '0;
    req_ch.end_year    = '0;
    req_ch.include_end = 1'b0;
    row_typed          = 1'b0;
    row_want           = '0;
    stress_go          = 1'b0;
    quiet              = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table.
    for (int r = 0; r < DirRows; r++) begin
      p.sd        = DayW'(dir_tab[r].sd);
      p.sm        = MonthW'(dir_tab[r].sm);
      p.sy        = YearW'(dir_tab[r].sy);
      p.ed        = DayW'(dir_tab[r].ed);
      p.em        = MonthW'(dir_tab[r].em);
      p.ey        = YearW'(dir_tab[r].ey);
      p.inc       = dir_tab[r].inc[0];
      want.count  = CountW'(dir_tab[r].cnt);
      want.status = dir_tab[r].st;
      offer(p, dir_tab[r].typed[0], want);
    end

    // Random part opens with the long receiver hold-off; keep offering through it.
    stress_go <= 1'b1;
    for (int n = 0; n < RandCount; n++) begin
      if (n == RandCount - QuietTail) quiet <= 1'b1;
      offer(make_random_pair(), 1'b0, '0);
    end
    req_ch.valid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (span_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fails == 0) begin
      $display("** date_period_length_days_unit: PASSED **");
    end else begin
      $display("** date_period_length_days_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
